>>> rtl/core/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg - shared types and constants of the grid ray caster
// Request and configuration types, sequencer states, fixed-point sizes and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

	// tile side in Q8 units is 1 << TQ_SHIFT (64 pixels, 8 fraction bits)
	localparam int TQ_SHIFT     = 14;
	localparam int TQ           = 1 << TQ_SHIFT;
	localparam int CORDIC_STEPS = 14;
	localparam int NUM_W        = 29;   // divider dividend width
	localparam int DEN_W        = 15;   // divider divisor width
	localparam int MAG_W        = 23;   // hit coordinate and distance magnitude
	localparam int SQ_W         = 46;   // squared distance
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = 2;

	// configuration register indexes
	localparam logic [2:0] CFG_MAP_COLS   = 3'd0;
	localparam logic [2:0] CFG_MAP_ROWS   = 3'd1;
	localparam logic [2:0] CFG_PLAYER_X   = 3'd2;
	localparam logic [2:0] CFG_PLAYER_Y   = 3'd3;
	localparam logic [2:0] CFG_VIEW_ANGLE = 3'd4;

	// request type codes on the input channel
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CAST  = 1'b1;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_CAST,
		KIND_DROP
	} req_kind_t;

	typedef struct packed {
		req_kind_t   kind;
		logic [5:0]  col;
		logic [5:0]  row;
		logic        wall;
		logic [15:0] angle;
	} req_item_t;

	typedef struct packed {
		logic [6:0]  map_cols;
		logic [6:0]  map_rows;
		logic [19:0] player_x;
		logic [19:0] player_y;
		logic [15:0] view_dir;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIR,
		ST_W_INIT,
		ST_W_MUL,
		ST_W_DIV,
		ST_W_CHECK,
		ST_W_READ,
		ST_W_END,
		ST_D_SQX,
		ST_D_SQY,
		ST_D_ROOT,
		ST_VIEW,
		ST_FIN,
		ST_OUT
	} back_state_t;

	// arctangent of 2^-i in binary angle units (65536 per turn)
	function automatic logic [13:0] atan_entry(input logic [3:0] i);
		logic [13:0] v;
		case (i)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/gcr_ram.sv
// ----------------------------------------------------------------------------
// gcr_ram - generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/core/gcr_front.sv
// ----------------------------------------------------------------------------
// gcr_front - request intake and classification
// Registers each request, sorts it into write, cast or drop and hands it
// to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_front #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clearing,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              req_type,
	input  logic [5:0]        cell_col,
	input  logic [5:0]        cell_row,
	input  logic              cell_wall,
	input  logic [15:0]       cast_angle,
	input  logic              q_full,
	output logic              push,
	output gcr_pkg::req_item_t item
);

	import gcr_pkg::*;

	logic      stage_valid_s1;
	req_item_t item_s1;
	req_item_t item_n;
	logic      accept;

	assign push      = stage_valid_s1 && !q_full;
	assign req_ready = !clearing && (!stage_valid_s1 || !q_full);
	assign accept    = req_valid && req_ready;
	assign item      = item_s1;

	// classify the incoming request
	always_comb begin
		item_n.col   = cell_col;
		item_n.row   = cell_row;
		item_n.wall  = cell_wall;
		item_n.angle = cast_angle;
		if (req_type == REQ_CAST) begin
			item_n.kind = KIND_CAST;
		end else if (9'(cell_col) >= 9'(MAX_COLS) || 9'(cell_row) >= 9'(MAX_ROWS)) begin
			item_n.kind = KIND_DROP;
		end else begin
			item_n.kind = KIND_WRITE;
		end
	end

	// hold the stage until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_s1 <= 1'b0;
		end else if (accept) begin
			stage_valid_s1 <= 1'b1;
		end else if (push) begin
			stage_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/gcr_queue.sv
// ----------------------------------------------------------------------------
// gcr_queue - short request queue
// Decouples the intake stage from the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gcr_pkg::req_item_t push_item,
	input  logic               pop,
	output gcr_pkg::req_item_t head,
	output logic               full,
	output logic               empty
);

	import gcr_pkg::*;

	req_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/gcr_back.sv
// ----------------------------------------------------------------------------
// gcr_back - ray walking sequencer
// Holds the wall map, applies cell writes, and runs each cast through a
// shared CORDIC, divider and square-root unit one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_back #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gcr_pkg::cfg_t      cfg,
	input  gcr_pkg::req_item_t item,
	input  logic               q_empty,
	output logic               pop,
	output logic               clearing,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [20:0]        wall_distance,
	output logic               hit_found,
	output logic               hit_vertical,
	output logic [19:0]        hit_x,
	output logic [19:0]        hit_y
);

	import gcr_pkg::*;

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);

	back_state_t state_q, state_n;
	logic [AW-1:0] clr_addr_q;
	logic          res_valid_q;
	logic          out_free;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic          ram_rdata;

	// map extent
	logic [8:0]         cols_n, rows_n;
	logic signed [31:0] ext_w, ext_h, pos_x, pos_y;

	// CORDIC unit
	logic signed [17:0] cx_q, cy_q, xs, ys;
	logic signed [16:0] cz_q, atan_s;
	logic [3:0]         cstep_q;
	logic [1:0]         cquad_q;
	logic               czero_q;
	logic               cordic_view_q;
	logic signed [15:0] xc, yc, dir_c, dir_s;
	logic [15:0]        cordic_ang;
	logic signed [15:0] c_q, s_q, cf_q;
	logic [15:0]        ang_q;

	// walk
	logic               walk_v_q;
	logic signed [15:0] da, db, da_neg_v, db_neg_v;
	logic signed [31:0] pa, pb, la, lb;
	logic signed [31:0] a_q, b_q, sb_q, a_init, ap, probe_x, probe_y;
	logic               da_neg_q, db_neg_q;
	logic [DEN_W-1:0]   den_q, off_mag_q, dbm_q, off_mag_n;
	logic               out_rng, outside;
	logic [AW-1:0]      probe_addr;

	// divider
	logic [DEN_W-1:0]   rem_q, rem_n;
	logic [NUM_W-1:0]   quo_q, quo_n;
	logic [DEN_W:0]     trial;
	logic               ge;
	logic [4:0]         dcnt_q;
	logic               div_pass_q;
	logic signed [31:0] qv, qs;

	// hits
	logic             hit_h_q, hit_v_q;
	logic [MAG_W-1:0] hx_q, hy_q, vx_q, vy_q;

	// distance
	logic               dist_v_q;
	logic [MAG_W-1:0]   sel_x, sel_y, mag_x, mag_y;
	logic signed [23:0] dx, dy;
	logic [SQ_W-1:0]    sq_q, rv_q, res_q, bit_q, root_trial, res_next;
	logic [MAG_W-1:0]   dh_q, dv_q;
	logic               pick_vert, pick_q;
	logic [MAG_W-1:0]   dsel;
	logic [37:0]        prod;
	logic [20:0]        dist_q;
	logic [MAG_W-1:0]   out_x, out_y;

	gcr_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign clearing  = state_q == ST_CLEAR;
	assign res_valid = res_valid_q;
	assign out_free  = !res_valid_q || res_ready;

	// clamp the map size and form the extent
	always_comb begin
		if ({2'b00, cfg.map_cols} > 9'(MAX_COLS)) begin
			cols_n = 9'(MAX_COLS);
		end else if (cfg.map_cols == '0) begin
			cols_n = 9'd1;
		end else begin
			cols_n = {2'b00, cfg.map_cols};
		end
		if ({2'b00, cfg.map_rows} > 9'(MAX_ROWS)) begin
			rows_n = 9'(MAX_ROWS);
		end else if (cfg.map_rows == '0) begin
			rows_n = 9'd1;
		end else begin
			rows_n = {2'b00, cfg.map_rows};
		end
	end

	assign ext_w = {9'd0, cols_n, 14'd0};
	assign ext_h = {9'd0, rows_n, 14'd0};
	assign pos_x = {12'd0, cfg.player_x};
	assign pos_y = {12'd0, cfg.player_y};

	// CORDIC step and quadrant rotation
	assign xs         = cx_q >>> cstep_q;
	assign ys         = cy_q >>> cstep_q;
	assign atan_s     = {3'b000, atan_entry(cstep_q)};
	assign xc         = cx_q[17] ? 16'sd0 : cx_q[15:0];
	assign yc         = cy_q[17] ? 16'sd0 : cy_q[15:0];
	assign cordic_ang = ang_q - cfg.view_dir;

	always_comb begin
		case (cquad_q)
			2'd0: begin
				dir_c = xc;
				dir_s = yc;
			end
			2'd1: begin
				dir_c = -yc;
				dir_s = xc;
			end
			2'd2: begin
				dir_c = -xc;
				dir_s = -yc;
			end
			default: begin
				dir_c = yc;
				dir_s = -xc;
			end
		endcase
	end

	// walk axes: horizontal walk steps along y, vertical along x
	assign da       = walk_v_q ? c_q : s_q;
	assign db       = walk_v_q ? s_q : c_q;
	assign pa       = walk_v_q ? pos_x : pos_y;
	assign pb       = walk_v_q ? pos_y : pos_x;
	assign la       = walk_v_q ? ext_w : ext_h;
	assign lb       = walk_v_q ? ext_h : ext_w;
	assign da_neg_v = -da;
	assign db_neg_v = -db;
	assign a_init   = {pa[31:TQ_SHIFT], 14'd0} + (da[15] ? 32'sd0 : 32'(TQ));
	assign off_mag_n = da[15] ? {1'b0, pa[13:0]} : DEN_W'(TQ) - {1'b0, pa[13:0]};

	// probe point of the current crossing
	assign out_rng = (a_q < 0) || (a_q > la) || (b_q < 0) || (b_q > lb);
	assign ap      = a_q - (da_neg_q ? 32'sd1 : 32'sd0);
	assign probe_x = walk_v_q ? ap : b_q;
	assign probe_y = walk_v_q ? b_q : ap;
	assign outside = (probe_x < 0) || (probe_y < 0) || (probe_x >= ext_w) || (probe_y >= ext_h);
	assign probe_addr = AW'(probe_y[TQ_SHIFT +: 8]) * AW'(MAX_COLS)
		+ AW'(probe_x[TQ_SHIFT +: 8]);

	// restoring divider step
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign rem_n = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	assign quo_n = {quo_q[NUM_W-2:0], ge};
	assign qv    = $signed({3'b000, quo_n});
	assign qs    = db_neg_q ? -qv : qv;

	// distance operands
	assign sel_x = dist_v_q ? vx_q : hx_q;
	assign sel_y = dist_v_q ? vy_q : hy_q;
	assign dx    = $signed({1'b0, sel_x}) - $signed({4'd0, cfg.player_x});
	assign dy    = $signed({1'b0, sel_y}) - $signed({4'd0, cfg.player_y});
	assign mag_x = dx[23] ? MAG_W'(-dx) : dx[MAG_W-1:0];
	assign mag_y = dy[23] ? MAG_W'(-dy) : dy[MAG_W-1:0];

	// square root step
	assign root_trial = res_q + bit_q;
	assign res_next   = (rv_q >= root_trial) ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// pick the nearer hit and correct it
	assign pick_vert = !hit_h_q || (hit_v_q && dv_q < dh_q);
	assign dsel      = pick_vert ? dv_q : dh_q;
	assign prod      = dsel * cf_q[14:0];
	assign out_x     = pick_q ? vx_q : hx_q;
	assign out_y     = pick_q ? vy_q : hy_q;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty && item.kind == KIND_CAST) begin
					state_n = ST_DIR;
				end
			end
			ST_DIR: begin
				if (cstep_q == 4'(CORDIC_STEPS)) begin
					state_n = cordic_view_q ? ST_FIN : ST_W_INIT;
				end
			end
			ST_W_INIT: begin
				state_n = (da == '0) ? ST_W_END : ST_W_MUL;
			end
			ST_W_MUL: begin
				state_n = ST_W_DIV;
			end
			ST_W_DIV: begin
				if (dcnt_q == 5'(NUM_W - 1) && div_pass_q) begin
					state_n = ST_W_CHECK;
				end
			end
			ST_W_CHECK: begin
				if (out_rng || outside) begin
					state_n = ST_W_END;
				end else begin
					state_n = ST_W_READ;
				end
			end
			ST_W_READ: begin
				state_n = ram_rdata ? ST_W_END : ST_W_CHECK;
			end
			ST_W_END: begin
				if (!walk_v_q) begin
					state_n = ST_W_INIT;
				end else if (!hit_h_q && !hit_v_q) begin
					state_n = ST_OUT;
				end else begin
					state_n = ST_D_SQX;
				end
			end
			ST_D_SQX: begin
				state_n = ST_D_SQY;
			end
			ST_D_SQY: begin
				state_n = ST_D_ROOT;
			end
			ST_D_ROOT: begin
				if (bit_q[0]) begin
					state_n = (!dist_v_q && hit_v_q) ? ST_D_SQX : ST_VIEW;
				end
			end
			ST_VIEW: begin
				state_n = ST_DIR;
			end
			ST_FIN: begin
				state_n = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// map port and queue pop
	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = 1'b0;
		ram_raddr = probe_addr;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				pop = !q_empty;
				if (!q_empty && item.kind == KIND_WRITE) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(item.row) * AW'(MAX_COLS) + AW'(item.col);
					ram_wdata = item.wall;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// start a cast: load the ray angle into the CORDIC
				ang_q         <= item.angle;
				cordic_view_q <= 1'b0;
				hit_h_q       <= 1'b0;
				hit_v_q       <= 1'b0;
				cstep_q       <= '0;
				cquad_q       <= item.angle[15:14];
				czero_q       <= item.angle[13:0] == '0;
				cx_q          <= (item.angle[13:0] == '0) ? 18'sd16384 : 18'sd9949;
				cy_q          <= '0;
				cz_q          <= {3'b000, item.angle[13:0]};
			end
			ST_DIR: begin
				// rotate on the first steps, then take the result
				cstep_q <= cstep_q + 1'b1;
				if (!czero_q && cstep_q != 4'(CORDIC_STEPS)) begin
					if (!cz_q[16]) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - atan_s;
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + atan_s;
					end
				end
				walk_v_q <= 1'b0;
			end
			ST_W_INIT: begin
				a_q        <= a_init;
				da_neg_q   <= da[15];
				db_neg_q   <= db[15];
				den_q      <= da[15] ? da_neg_v[DEN_W-1:0] : da[DEN_W-1:0];
				dbm_q      <= db[15] ? db_neg_v[DEN_W-1:0] : db[DEN_W-1:0];
				off_mag_q  <= off_mag_n;
				div_pass_q <= 1'b0;
			end
			ST_W_MUL: begin
				quo_q  <= NUM_W'(off_mag_q) * NUM_W'(dbm_q);
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ST_W_DIV: begin
				rem_q  <= rem_n;
				quo_q  <= quo_n;
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == 5'(NUM_W - 1)) begin
					if (!div_pass_q) begin
						// offset done: start the step division
						b_q        <= pb + qs;
						div_pass_q <= 1'b1;
						quo_q      <= {dbm_q, 14'd0};
						rem_q      <= '0;
						dcnt_q     <= '0;
					end else begin
						sb_q <= qs;
					end
				end
			end
			ST_W_CHECK: begin
				if (!out_rng && outside) begin
					if (walk_v_q) begin
						hit_v_q <= 1'b1;
						vx_q    <= a_q[MAG_W-1:0];
						vy_q    <= b_q[MAG_W-1:0];
					end else begin
						hit_h_q <= 1'b1;
						hx_q    <= b_q[MAG_W-1:0];
						hy_q    <= a_q[MAG_W-1:0];
					end
				end
			end
			ST_W_READ: begin
				if (ram_rdata) begin
					if (walk_v_q) begin
						hit_v_q <= 1'b1;
						vx_q    <= a_q[MAG_W-1:0];
						vy_q    <= b_q[MAG_W-1:0];
					end else begin
						hit_h_q <= 1'b1;
						hx_q    <= b_q[MAG_W-1:0];
						hy_q    <= a_q[MAG_W-1:0];
					end
				end else begin
					a_q <= a_q + (da_neg_q ? -32'(TQ) : 32'(TQ));
					b_q <= b_q + sb_q;
				end
			end
			ST_W_END: begin
				walk_v_q <= 1'b1;
				dist_v_q <= !hit_h_q;
			end
			ST_D_SQX: begin
				sq_q <= mag_x * mag_x;
			end
			ST_D_SQY: begin
				rv_q  <= sq_q + mag_y * mag_y;
				res_q <= '0;
				bit_q <= SQ_W'(1) << (SQ_W - 2);
			end
			ST_D_ROOT: begin
				if (rv_q >= root_trial) begin
					rv_q <= rv_q - root_trial;
				end
				res_q <= res_next;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					if (dist_v_q) begin
						dv_q <= res_next[MAG_W-1:0];
					end else begin
						dh_q <= res_next[MAG_W-1:0];
					end
					dist_v_q <= 1'b1;
				end
			end
			ST_VIEW: begin
				// fisheye correction angle through the same CORDIC
				cordic_view_q <= 1'b1;
				cstep_q       <= '0;
				cquad_q       <= cordic_ang[15:14];
				czero_q       <= cordic_ang[13:0] == '0;
				cx_q          <= (cordic_ang[13:0] == '0) ? 18'sd16384 : 18'sd9949;
				cy_q          <= '0;
				cz_q          <= {3'b000, cordic_ang[13:0]};
			end
			ST_FIN: begin
				pick_q <= pick_vert;
				if (cf_q <= 0) begin
					dist_q <= '0;
				end else if (prod[37:35] != '0) begin
					dist_q <= '1;
				end else begin
					dist_q <= prod[34:14];
				end
			end
			ST_OUT: begin
				if (out_free) begin
					if (!hit_h_q && !hit_v_q) begin
						wall_distance <= '1;
						hit_found     <= 1'b0;
						hit_vertical  <= 1'b0;
						hit_x         <= '0;
						hit_y         <= '0;
					end else begin
						wall_distance <= dist_q;
						hit_found     <= 1'b1;
						hit_vertical  <= pick_q;
						hit_x         <= (out_x[22:20] != '0) ? 20'hFFFFF : out_x[19:0];
						hit_y         <= (out_y[22:20] != '0) ? 20'hFFFFF : out_y[19:0];
					end
				end
			end
			default: begin
				dcnt_q <= dcnt_q;
			end
		endcase
		// latch the CORDIC result once all steps are done
		if (state_q == ST_DIR && cstep_q == 4'(CORDIC_STEPS)) begin
			if (cordic_view_q) begin
				cf_q <= dir_c;
			end else begin
				c_q <= dir_c;
				s_q <= dir_s;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/grid_ray_caster.sv
// ----------------------------------------------------------------------------
// grid_ray_caster - tile map ray caster
// Wall map store and grid-line walking ray caster with fisheye correction.
// ----------------------------------------------------------------------------
// Usage: requests enter on req_valid/req_ready. A write request stores one
// map cell and gives no result; a cast request gives one result on
// res_valid/res_ready. Configuration registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce.
// After reset all MAX_COLS*MAX_ROWS cells of the map store (4096 by default)
// are swept to open cells, one cell a cycle; req_ready stays low meanwhile.
// A cast runs on one sequencer: pick-up and the ray CORDIC, then per walk
// set-up, the offset and step divisions and a map read for each tile
// crossing probed, then, if either walk hit, a square root per walk that
// hit, the correction CORDIC and a finish step.
// A four-entry queue sits between intake and sequencer, so requests are
// taken while a cast runs. The result is held in an output register; a
// stalled receiver halts the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_caster #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        req_type,
	input  logic [5:0]  cell_col,
	input  logic [5:0]  cell_row,
	input  logic        cell_wall,
	input  logic [15:0] cast_angle,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [20:0] wall_distance,
	output logic        hit_found,
	output logic        hit_vertical,
	output logic [19:0] hit_x,
	output logic [19:0] hit_y
);

	import gcr_pkg::*;

	cfg_t      cfg_q;
	logic      clearing;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;
	req_item_t front_item;
	req_item_t head_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_cols <= 7'd64;
			cfg_q.map_rows <= 7'd64;
			cfg_q.player_x <= '0;
			cfg_q.player_y <= '0;
			cfg_q.view_dir <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_COLS:   cfg_q.map_cols <= cfg_data[6:0];
				CFG_MAP_ROWS:   cfg_q.map_rows <= cfg_data[6:0];
				CFG_PLAYER_X:   cfg_q.player_x <= cfg_data;
				CFG_PLAYER_Y:   cfg_q.player_y <= cfg_data;
				CFG_VIEW_ANGLE: cfg_q.view_dir <= cfg_data[15:0];
				default:        cfg_q          <= cfg_q;
			endcase
		end
	end

	gcr_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.cell_col   (cell_col),
		.cell_row   (cell_row),
		.cell_wall  (cell_wall),
		.cast_angle (cast_angle),
		.q_full     (q_full),
		.push       (push),
		.item       (front_item)
	);

	gcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head      (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	gcr_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item          (head_item),
		.q_empty       (q_empty),
		.pop           (pop),
		.clearing      (clearing),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.wall_distance (wall_distance),
		.hit_found     (hit_found),
		.hit_vertical  (hit_vertical),
		.hit_x         (hit_x),
		.hit_y         (hit_y)
	);

	// no request is taken during the map sweep
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req_ready)
		else $error("request taken during map sweep");

	// queue stays empty until the sweep ends
	a_queue_empty_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> q_empty)
		else $error("queue filled during map sweep");

	// no result before the sweep ends
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !res_valid)
		else $error("result during map sweep");

endmodule

`default_nettype wire
